// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/b32ops_pkg.sv =====
// package for the binary32 bit-level operations unit
// operation codes and bit-pattern constants, no dependencies
package b32ops_pkg;
	typedef enum logic [2:0] {
		FUNC_NEG  = 3'd0,
		FUNC_ABS  = 3'd1,
		FUNC_TWICE = 3'd2,
		FUNC_HALF = 3'd3,
		FUNC_F2I  = 3'd4,
		FUNC_I2F  = 3'd5
	} func_t;

	localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
	localparam logic [31:0] MAG_MASK  = 32'h7fff_ffff;
	localparam logic [31:0] HIDDEN    = 32'h0080_0000;
	localparam logic [31:0] INT_ERROR = 32'h8000_0000;
	localparam logic [7:0]  EXP_BIAS  = 8'd127;
	localparam logic [7:0]  EXP_LIMIT = 8'd158;
endpackage

// ===== hdl/binary32_bit_level_ops_unit.sv =====
// top level of the binary32 bit-level operations unit
// depends on b32ops_pkg
//
// usage:
//  input channel (valid/ready) carries func and operand, one beat per item
//  output channel (valid/ready) carries result, one beat per item
//  func: 0 negate, 1 abs, 2 twice, 3 half, 4 float-to-int, 5 int-to-float,
//  codes 6 and 7 give zero
//  the operand is captured in an input register (s1); combinational work
//  (leading-one detect, shift, round) feeds the result register (s2)
//  each item passes through s1 and then s2, which drives the output
//  throughput: one item per cycle while the receiver takes results
//  when the receiver stalls, the s2 stage holds and s1 fills; ready drops
//  only when both hold an item, so no beat is lost or repeated
//  reset clears both valid flags; nothing else needs reset
//  the rate is set by the single stage of shift-and-round logic between
//  the two registers
module binary32_bit_level_ops_unit
	import b32ops_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result
);
	logic        vld_s1, vld_s2;
	logic [2:0]  func_s1;
	logic [31:0] opnd_s1, res_s2, res_c;
	logic        adv_s1;

	assign adv_s1   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (!vld_s2 || out_ready) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			opnd_s1 <= operand;
		end
		if (adv_s1) res_s2 <= res_c;
	end

	assign out_valid = vld_s2;
	assign result    = res_s2;

	// datapath
	logic        sgn, is_nan, frz;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic [31:0] r_twice, r_half, r_f2i, r_i2f;
	logic [30:0] hm;
	logic [31:0] v, vs;
	logic [7:0]  e;
	logic [31:0] u, nrm;
	logic [4:0]  p;
	logic [24:0] m;
	logic        rnd;
	logic [7:0]  ef;

	always_comb begin
		sgn    = opnd_s1[31];
		ex     = opnd_s1[30:23];
		fr     = opnd_s1[22:0];
		is_nan = (ex == 8'hff) && (fr != 23'd0);
		frz    = 1'b0;

		// twice
		if (ex == 8'hff) r_twice = opnd_s1;
		else if (ex == 8'd0) r_twice = {sgn, opnd_s1[29:0], 1'b0};
		else if (ex == 8'hfe) r_twice = {sgn, 8'hff, 23'd0};
		else r_twice = {sgn, ex + 8'd1, fr};

		// half
		hm = {1'b0, opnd_s1[30:1]} + {30'd0, opnd_s1[0] & opnd_s1[1]};
		if (ex == 8'hff) r_half = opnd_s1;
		else if (ex > 8'd1) r_half = opnd_s1 - HIDDEN;
		else r_half = {sgn, hm};

		// float to int
		e  = ex - EXP_BIAS;
		v  = {8'd0, 1'b1, fr};
		if (e > 8'd23) vs = v << (e[4:0] - 5'd23);
		else vs = v >> (5'd23 - e[4:0]);
		if (ex == 8'hff || ex >= EXP_LIMIT) r_f2i = INT_ERROR;
		else if (ex < EXP_BIAS) r_f2i = 32'd0;
		else r_f2i = sgn ? (32'd0 - vs) : vs;

		// int to float
		u = sgn ? (32'd0 - opnd_s1) : opnd_s1;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (u[i]) p = 5'(i);
		end
		nrm = u << (5'd31 - p);
		rnd = nrm[7] && (nrm[8] || (nrm[6:0] != 7'd0));
		m   = {1'b0, nrm[31:8]} + {24'd0, rnd};
		ef  = {3'd0, p} + EXP_BIAS + {7'd0, m[24]};
		if (u == 32'd0) r_i2f = 32'd0;
		else r_i2f = {sgn, ef, m[24] ? m[23:1] : m[22:0]};

		case (func_s1)
			FUNC_NEG:   res_c = is_nan ? opnd_s1 : (opnd_s1 ^ SIGN_BIT);
			FUNC_ABS:   res_c = is_nan ? opnd_s1 : (opnd_s1 & MAG_MASK);
			FUNC_TWICE: res_c = r_twice;
			FUNC_HALF:  res_c = r_half;
			FUNC_F2I:   res_c = r_f2i;
			FUNC_I2F:   res_c = r_i2f;
			default:    res_c = {31'd0, frz};
		endcase
	end
endmodule

// ===== hdl/b32ops_checker.sv =====
// port-level checker for the binary32 bit-level operations unit
// depends on assert_macros.svh; bound to the top level below
`include "assert_macros.svh"
module b32ops_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result))
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`ASSERT_NEXT(a_beat_reaches_out, clk, arst_n, in_valid && in_ready, ##1 out_valid)
endmodule

bind binary32_bit_level_ops_unit b32ops_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result(result)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for binary32_bit_level_ops_unit
// predicts each result from the operation code and operand, checks output beats in order
// depends on b32ops_pkg and the unit's rtl
module tb_top;
	import b32ops_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  fn;
		logic [31:0] opd;
	} op_item_t;

	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] FUNC_UNDEF6 = 3'd6;
	localparam logic [2:0] FUNC_UNDEF7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  func = '0;
	logic [31:0] operand = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result;

	op_item_t    pending_ops[$];
	logic [31:0] expected_results[$];
	int          error_count = 0;
	int          idle_cycles = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	bit          hold_for_drain = 1'b0;
	bit          stim_done = 1'b0;
	int          stall_phase = 0;

	binary32_bit_level_ops_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .operand(operand),
		.out_valid(out_valid), .out_ready(out_ready), .result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] b32_compute(logic [2:0] fn, logic [31:0] f);
		logic [7:0]  ex;
		logic [31:0] mag, m, u, lost, halfway, v;
		int          p, s, e;
		ex = f[30:23];
		mag = f & MAG_MASK;
		case (fn)
			FUNC_NEG: begin
				return (ex == 8'hff && f[22:0] != 0) ? f : f ^ SIGN_BIT;
			end
			FUNC_ABS: begin
				return (ex == 8'hff && f[22:0] != 0) ? f : mag;
			end
			FUNC_TWICE: begin
				if (ex == 8'hff) return f;
				if (ex == 8'h00) return (f & SIGN_BIT) | (mag << 1);
				ex = ex + 8'd1;
				return {f[31], ex, (ex == 8'hff) ? 23'd0 : f[22:0]};
			end
			FUNC_HALF: begin
				if (ex == 8'hff) return f;
				if (ex > 8'd1) return f - HIDDEN;
				m = mag >> 1;
				if (mag[0] && m[0]) m = m + 1;
				return (f & SIGN_BIT) | m;
			end
			FUNC_F2I: begin
				if (ex == 8'hff || ex >= EXP_LIMIT) return INT_ERROR;
				if (ex < EXP_BIAS) return 32'd0;
				e = ex - EXP_BIAS;
				v = HIDDEN | {9'd0, f[22:0]};
				v = (e > 23) ? v << (e - 23) : v >> (23 - e);
				return f[31] ? -v : v;
			end
			FUNC_I2F: begin
				u = f[31] ? -f : f;
				if (u == 0) return 32'd0;
				p = 0;
				for (int i = 0; i < 32; i++)
					if (u[i]) p = i;
				if (p <= 23) begin
					m = u << (23 - p);
				end else begin
					s = p - 23;
					lost = u & ((32'd1 << s) - 1);
					halfway = 32'd1 << (s - 1);
					m = u >> s;
					if (lost > halfway || (lost == halfway && m[0])) m = m + 1;
					if (m[24]) begin
						m = m >> 1;
						p++;
					end
				end
				return (f & SIGN_BIT) | ((p + EXP_BIAS) << 23) | (m & 32'h007f_ffff);
			end
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [31:0] rand_operand();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 7))
			0: x[30:23] = 8'($urandom_range(0, 1));
			1: x[30:23] = 8'hff;
			2: x[30:23] = 8'($urandom_range(120, 160));
			3: x[30:23] = 8'($urandom_range(252, 254));
			4: x = x >> $urandom_range(0, 31);
			5: x = (x & 32'h8000_0000) | (32'h00ff_ffff >> $urandom_range(0, 8)
				<< $urandom_range(0, 8));
			default: ;
		endcase
		return x;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(b32_compute(func, operand));
			end
			if (!in_valid || in_ready) begin
				if (hold_for_drain && expected_results.size() == 0 && !(in_valid && in_ready))
					hold_for_drain <= 1'b0;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (hold_for_drain || pending_ops.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					op_item_t it;
					it = pending_ops.pop_front();
					if (it.fn == 3'bxxx) it.fn = '0;
					in_valid <= 1'b1;
					func <= it.fn;
					operand <= it.opd;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// receiver stall pattern and monitor
	always @(posedge clk) begin
		logic [31:0] exp_r;
		stall_phase <= stall_phase + 1;
		if (stall_phase % 400 < 100) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, actual %08h", $time, result);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result !== exp_r) begin
					$display("%0t: result mismatch, expected %08h actual %08h",
						$time, exp_r, result);
					error_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		op_item_t it;
		logic [31:0] dir_ops[$];
		dir_ops = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
			32'h7fc0_0001, 32'h0000_0001, 32'h0000_0003, 32'h807f_ffff,
			32'h0080_0000, 32'h00ff_ffff, 32'h7f7f_ffff, 32'h3f80_0000,
			32'h3f7f_ffff, 32'hcf00_0000, 32'h4f00_0000, 32'h7fff_ffff,
			32'hffff_ffff, 32'h0100_0001, 32'h0200_0003, 32'hbfc0_0000};
		foreach (dir_ops[i]) begin
			it.fn = 3'(i % 8);
			it.opd = dir_ops[i];
			pending_ops.push_back(it);
		end
		it.fn = FUNC_UNDEF7;
		it.opd = 32'hffff_ffff;
		pending_ops.push_back(it);
		it.fn = FUNC_UNDEF6;
		pending_ops.push_back(it);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0);
		@(posedge clk);
		hold_for_drain <= 1'b1;
		for (int i = 0; i < 650; i++) begin
			it.fn = ($urandom_range(0, 20) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			it.opd = rand_operand();
			pending_ops.push_back(it);
		end
		wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/b32ops_pkg.sv
hdl/binary32_bit_level_ops_unit.sv
hdl/b32ops_checker.sv
verif/tb_top.sv
